>>> src/itoa_pkg.sv
// itoa_pkg: shared types and character constants for the signed integer to
// decimal ascii unit. no dependencies.
package itoa_pkg;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] char_t;

  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;
  localparam char_t CHAR_MINUS = 8'h2D;

  // handoff from the bcd converter to the character emitter
  typedef struct packed {
    logic valid;
    logic neg;
  } bcd_ctl_t;

endpackage

>>> src/itoa_dd.sv
// itoa_dd: bit-serial binary to bcd converter (shift and add-3), one input
// bit per cycle. depends on itoa_pkg.
module itoa_dd import itoa_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_BITS-1:0]  in_value,
  output bcd_ctl_t               bcd_ctl,
  input  logic                   bcd_take,
  output logic [NDIG*4-1:0]      bcd_digits
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [NDIG*4-1:0]     bcd_r, bcd_nxt;
  logic [NDIG*4-1:0]     bcd_adj;
  logic                  neg_r, neg_nxt;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_value[VALUE_BITS-1];
          mag_nxt   = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_BITS);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        bcd_nxt = {bcd_adj[NDIG*4-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (bcd_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign bcd_ctl.valid = (state_r == ST_DONE);
  assign bcd_ctl.neg   = neg_r;
  assign bcd_digits    = bcd_r;

endmodule

>>> src/itoa_emit.sv
// itoa_emit: strips leading zero digits one per cycle, then sends the sign
// and digits through an output register. depends on itoa_pkg.
module itoa_emit import itoa_pkg::*; #(
  parameter int NDIG = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bcd_ctl_t           bcd_ctl,
  output logic               bcd_take,
  input  logic [NDIG*4-1:0]  bcd_digits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_text_char,
  output logic               out_last_char
);

  localparam int CNT_W = $clog2(NDIG + 1);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SKIP  = 2'd1;
  localparam logic [1:0] ST_SIGN  = 2'd2;
  localparam logic [1:0] ST_DIGIT = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [NDIG*4-1:0]  bcd_r, bcd_nxt;
  logic               neg_r, neg_nxt;
  logic               ovld_r, ovld_nxt;
  char_t              ochar_r, ochar_nxt;
  logic               olast_r, olast_nxt;
  digit_t             top_digit;
  logic               out_free;
  logic               emit;

  assign top_digit = bcd_r[NDIG*4-1 -: 4];
  assign out_free  = !ovld_r || out_ready;
  assign bcd_take  = bcd_ctl.valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (bcd_ctl.valid) begin
          bcd_nxt   = bcd_digits;
          neg_nxt   = bcd_ctl.neg;
          cnt_nxt   = CNT_W'(NDIG);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // keep at least one digit so zero still gives '0'
        if (top_digit == 4'd0 && cnt_r != CNT_W'(1)) begin
          bcd_nxt = {bcd_r[NDIG*4-5:0], 4'd0};
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (neg_r) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          emit      = 1'b1;
          ochar_nxt = CHAR_MINUS;
          olast_nxt = 1'b0;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          emit      = 1'b1;
          ochar_nxt = CHAR_ZERO + {4'd0, top_digit};
          olast_nxt = (cnt_r == CNT_W'(1));
          bcd_nxt   = {bcd_r[NDIG*4-5:0], 4'd0};
          cnt_nxt   = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (emit) begin
      ovld_nxt = 1'b1;
    end else if (out_ready) begin
      ovld_nxt = 1'b0;
    end else begin
      ovld_nxt = ovld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r   <= bcd_nxt;
    neg_r   <= neg_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid     = ovld_r;
  assign out_text_char = ochar_r;
  assign out_last_char = olast_r;

endmodule

>>> src/signed_int_to_decimal_ascii_unit.sv
// signed_int_to_decimal_ascii_unit: converts a signed integer to decimal ascii,
// one character per transaction, built from itoa_dd and itoa_emit (itoa_pkg).
// a number passes through the serial shift run in the converter, a handoff, a
// leading zero scan, then goes out one character at a time (at most 11).
// the converter takes a new number only once its result is handed off, so
// character output of one number overlaps the next conversion.
// reset: synchronous active low rst_n clears control state; no clearing pass.
module signed_int_to_decimal_ascii_unit import itoa_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_text_char,
  output logic                  out_last_char
);

  // decimal digits of 2^(VALUE_BITS-1)
  localparam int NDIG = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

  bcd_ctl_t          bcd_ctl;
  logic              bcd_take;
  logic [NDIG*4-1:0] bcd_digits;

  itoa_dd #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_dd (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .bcd_ctl    (bcd_ctl),
    .bcd_take   (bcd_take),
    .bcd_digits (bcd_digits)
  );

  itoa_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .bcd_ctl       (bcd_ctl),
    .bcd_take      (bcd_take),
    .bcd_digits    (bcd_digits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  // converter is busy for the whole shift run after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while converter busy");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_char == CHAR_MINUS ||
                   (out_text_char >= CHAR_ZERO && out_text_char <= CHAR_NINE)))
    else $error("output character out of range");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_char == CHAR_MINUS |-> !out_last_char)
    else $error("sign flagged as last character");

endmodule

>>> dv/itoa_text_checker.sv
// itoa_text_checker: watches the number and character channels of the signed
// integer to decimal ascii unit, predicts each character and compares.
// depends on itoa_pkg for the character types and constants.
module itoa_text_checker import itoa_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_text_char,
  input  logic                  out_last_char,
  output int                    mismatch_count,
  output int                    text_pending
);

  typedef struct packed {
    char_t ch;
    logic  last;
  } text_char_t;

  text_char_t expected_text [$];
  int         err_cnt = 0;
  int         depth = 0;

  assign mismatch_count = err_cnt;
  assign text_pending   = depth;

  // queue the decimal text of one number, sign first, most significant digit next
  function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] mag;
    digit_t                digs [0:19];
    int                    n;
    logic                  neg;
    text_char_t            item;
    neg = value[VALUE_BITS-1];
    // magnitude of the most negative value still fits as unsigned
    mag = neg ? (~value + 1'b1) : value;
    n = 0;
    do begin
      digs[n] = digit_t'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0);
    if (neg) begin
      item.ch   = CHAR_MINUS;
      item.last = 1'b0;
      expected_text.push_back(item);
    end
    for (int k = n - 1; k >= 0; k--) begin
      item.ch   = CHAR_ZERO + {4'b0000, digs[k]};
      item.last = (k == 0);
      expected_text.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t exp_item;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_text(in_value);
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character transaction: text_char %h last_char %b",
                 out_text_char, out_last_char);
          err_cnt++;
        end else begin
          exp_item = expected_text.pop_front();
          if (out_text_char !== exp_item.ch) begin
            $error("text_char mismatch: expected %h actual %h", exp_item.ch, out_text_char);
            err_cnt++;
          end
          if (out_last_char !== exp_item.last) begin
            $error("last_char mismatch: expected %b actual %b", exp_item.last, out_last_char);
            err_cnt++;
          end
        end
      end
      depth <= expected_text.size();
    end
  end

endmodule

>>> dv/tb.sv
// tb: drives signed numbers into signed_int_to_decimal_ascii_unit and gives the verdict.
// depends on itoa_pkg, the unit itself and itoa_text_checker.
module tb;

  localparam int VALUE_BITS  = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 80;
  // receiver hold-off and quiet window, counted in receiver cycles
  localparam int HOLD_START  = 2500;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_START  = 6000;
  localparam int CALM_END    = 7500;
  localparam int RANDOM_NUMS = 188;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_text_char;
  logic                  out_last_char;
  int                    mismatch_count;
  int                    text_pending;
  int                    cycle_count = 0;
  logic                  sender_pauses;

  signed_int_to_decimal_ascii_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_text_char(out_text_char),
    .out_last_char(out_last_char)
  );

  itoa_text_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char),
    .mismatch_count(mismatch_count),
    .text_pending  (text_pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_value(input logic [VALUE_BITS-1:0] value);
    if (sender_pauses && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      do begin
        @(negedge clk);
      end while ($urandom_range(99) < 18);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  // mostly numbers of a chosen digit count, some at digit-count boundaries, some fully random, a few most negative
  function automatic logic [VALUE_BITS-1:0] random_value();
    int unsigned kind;
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    kind = $urandom_range(99);
    if (kind < 3) begin
      return {1'b1, {(VALUE_BITS-1){1'b0}}};
    end
    if (kind < 23) begin
      return $urandom();
    end
    ndig = $urandom_range(10, 1);
    lo = 1;
    repeat (ndig - 1) lo = lo * 10;
    hi = (ndig == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
    if (ndig == 1) begin
      lo = 0;
    end
    if (kind < 38) begin
      mag = $urandom_range(1) ? lo : hi;
    end else begin
      mag = $urandom_range(hi, lo);
    end
    return $urandom_range(1) ? -mag : mag;
  endfunction

  initial begin : receiver
    int rx_cycle;
    rx_cycle = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
        out_ready <= 1'b0;
      end else if (rx_cycle >= CALM_START && rx_cycle < CALM_END) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value      = '0;
    out_ready     = 1'b0;
    sender_pauses = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero, single digits, digit-count boundaries, both extremes and alternating bit patterns
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sd9);
    send_value(32'sd10);
    send_value(-32'sd10);
    send_value(32'sd99);
    send_value(32'sd100);
    send_value(-32'sd5);
    send_value(32'sd999999999);
    send_value(-32'sd999999999);
    send_value(32'sd1000000000);
    send_value(-32'sd1000000000);
    send_value(32'sd1234567890);
    send_value(-32'sd1234567890);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0001);
    send_value(32'sh8000_0000);
    send_value(32'sh5555_5555);
    send_value(32'shAAAA_AAAA);
    send_value(32'sd0);
    send_value(32'sh8000_0000);

    for (int i = 0; i < RANDOM_NUMS; i++) begin
      sender_pauses = !(i >= 100 && i < 140);
      send_value(random_value());
    end
    in_valid <= 1'b0;

    wait (text_pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && text_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
src/itoa_pkg.sv
src/itoa_dd.sv
src/itoa_emit.sv
src/signed_int_to_decimal_ascii_unit.sv
dv/itoa_text_checker.sv
dv/tb.sv
